// ===== rtl/rsrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rsrf_pkg
// Shared types and fixed widths of the replacement-selection run former.
// ----------------------------------------------------------------------------
package rsrf_pkg;

    localparam int KEY_W     = 32;   // key width, two's complement
    localparam int RUN_OUT_W = 16;   // run number width on the output port
    localparam int CFG_W     = 5;    // leaves_in_use register width

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLD_LD,
        S_BLD_INIT,
        S_RD,
        S_CMP,
        S_DRN_CHK,
        S_DRN_EMIT
    } state_t;

    // what started the current path replay
    typedef enum logic [1:0] {
        M_BUILD,
        M_KEY,
        M_DRAIN
    } mode_t;

endpackage

// ===== rtl/replacement_selection_run_former.sv =====
// ----------------------------------------------------------------------------
// replacement_selection_run_former
// Replacement-selection run former built on a loser tree held in RAM.
// ----------------------------------------------------------------------------
// Fill keys are parked in the next empty leaf. A replacing key is accepted, the
// current winner shows in the output register on the next cycle, and the next
// key is taken once the path of L = floor(log2(leaf + N)) loser nodes (L = 4
// for N = 16) is replayed, one node per cycle; the single read port of the
// loser RAM sets the rate. Build replays one path per leaf, drain one per key.
// rst_n is asynchronous, clears all control state; no RAM clearing pass.
module replacement_selection_run_former #(
    parameter int LEAVES   = 16,
    parameter int RUN_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: leaves_in_use
    input  logic                              cfg_wr_en,
    input  logic [rsrf_pkg::CFG_W-1:0]        cfg_wr_data,
    // input request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [rsrf_pkg::KEY_W-1:0] key_in,
    input  logic                              input_last,
    // output request channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rsrf_pkg::KEY_W-1:0] key_out,
    output logic [rsrf_pkg::RUN_OUT_W-1:0]    run_number,
    output logic                              output_last
);

    localparam int IW = $clog2(LEAVES);      // leaf / node index
    localparam int SW = $clog2(LEAVES + 1);  // size and fill counters

    // A leaf record as carried up the tree. The loser RAM keeps a copy of the
    // loser's leaf; that leaf cannot change while it sits in a node, since only
    // the winner leaf is ever rewritten or retired.
    typedef struct packed {
        logic [IW-1:0]              idx;
        logic [rsrf_pkg::KEY_W-1:0] key;
        logic [RUN_BITS-1:0]        run;
        logic                       ret;
    } rec_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    rsrf_pkg::state_t state_reg, state_next;
    rsrf_pkg::mode_t  mode_reg, mode_next;
    logic [rsrf_pkg::CFG_W-1:0] liu_reg;          // leaves_in_use
    logic [SW-1:0]    size_reg, size_next;        // size latched per stream
    logic [SW-1:0]    fill_reg, fill_next;
    logic [SW-1:0]    bi_reg, bi_next;            // build leaf counter
    logic [IW-1:0]    t_reg, t_next;              // current loser node
    logic             drain_reg, drain_next;      // input ended, drain after
    rec_t             chal_reg, chal_next;        // challenger moving up
    logic             chal_s_reg, chal_s_next;    // challenger is the sentinel
    rec_t             win_reg, win_next;          // current overall winner
    logic [LEAVES-1:0] nset_reg, nset_next;       // loser node holds a leaf
    logic [rsrf_pkg::KEY_W-1:0] pend_key_reg, pend_key_next;
    logic [RUN_BITS-1:0]        pend_run_reg, pend_run_next;

    logic                              out_valid_reg, out_valid_next;
    logic [rsrf_pkg::KEY_W-1:0]        key_out_reg, key_out_next;
    logic [rsrf_pkg::RUN_OUT_W-1:0]    run_out_reg, run_out_next;
    logic                              last_out_reg, last_out_next;

    // ------------------------------------------------------------------
    // Memories: loser nodes and leaf keys, registered reads
    // ------------------------------------------------------------------
    rec_t                       node_mem [LEAVES];
    logic [rsrf_pkg::KEY_W-1:0] leaf_mem [LEAVES];

    logic          node_we, node_re;
    logic [IW-1:0] node_wa, node_ra;
    rec_t          node_wd;
    rec_t          node_q;
    logic          nset_q;
    logic          leaf_we, leaf_re;
    logic [rsrf_pkg::KEY_W-1:0] leaf_q;

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        if (node_re)
        begin
            node_q <= node_mem[node_ra];
            nset_q <= nset_reg[node_ra];
        end
        if (leaf_we)
        begin
            leaf_mem[fill_reg[IW-1:0]] <= key_in;
        end
        if (leaf_re)
        begin
            leaf_q <= leaf_mem[bi_reg[IW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // a strictly beats b; sentinel beats every leaf; retired loses to live
    function automatic logic beats(rec_t a, logic a_s, rec_t b, logic b_s);
        logic r;
        if (b_s)
            r = 1'b0;
        else if (a_s)
            r = 1'b1;
        else if (a.ret || b.ret)
            r = !a.ret && b.ret;
        else if (a.run != b.run)
            r = a.run < b.run;
        else
            r = $signed(a.key) < $signed(b.key);
        return r;
    endfunction

    // first loser node above leaf s
    function automatic logic [IW-1:0] tstart(logic [IW-1:0] s, logic [SW-1:0] n);
        logic [SW:0] sum;
        sum = (SW+1)'(s) + (SW+1)'(n);
        return IW'(sum >> 1);
    endfunction

    logic          out_free;
    logic          in_acc;
    logic [6:0]    liu_x;
    logic [SW-1:0] size_clamp;
    logic [SW-1:0] eff_size;
    logic [RUN_BITS-1:0] new_run;
    logic          swap;
    rec_t          c_new;
    logic          c_new_s;
    logic [IW-1:0] t_half;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == rsrf_pkg::S_IDLE) && out_free);
    assign in_acc   = in_valid && !in_stall;

    // size clamp: below 2 acts as 2, above LEAVES as LEAVES
    assign liu_x      = 7'(liu_reg);
    assign size_clamp = (liu_x < 7'd2)          ? SW'(2) :
                        (liu_x > 7'(LEAVES))    ? SW'(LEAVES) : SW'(liu_x);
    assign eff_size   = (fill_reg == '0) ? size_clamp : size_reg;

    // a key below the one just emitted starts the next run (saturating)
    assign new_run = ($signed(key_in) < $signed(win_reg.key) && win_reg.run != '1)
                     ? win_reg.run + 1'b1 : win_reg.run;

    // one level of the replay: stored loser against the challenger
    assign swap    = beats(node_q, !nset_q, chal_reg, chal_s_reg);
    assign c_new   = swap ? node_q : chal_reg;
    assign c_new_s = swap ? !nset_q : chal_s_reg;
    assign t_half  = t_reg >> 1;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        size_next      = size_reg;
        fill_next      = fill_reg;
        bi_next        = bi_reg;
        t_next         = t_reg;
        drain_next     = drain_reg;
        chal_next      = chal_reg;
        chal_s_next    = chal_s_reg;
        win_next       = win_reg;
        nset_next      = nset_reg;
        pend_key_next  = pend_key_reg;
        pend_run_next  = pend_run_reg;
        out_valid_next = out_valid_reg;
        key_out_next   = key_out_reg;
        run_out_next   = run_out_reg;
        last_out_next  = last_out_reg;
        node_we = 1'b0;
        node_wa = t_reg;
        node_wd = chal_reg;
        node_re = 1'b0;
        node_ra = t_reg;
        leaf_we = 1'b0;
        leaf_re = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rsrf_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    size_next  = eff_size;
                    drain_next = input_last;
                    if (fill_reg < eff_size)
                    begin
                        // fill phase: park the key in the next empty leaf
                        leaf_we   = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        if ((SW'(fill_reg + 1'b1) == eff_size) || input_last)
                        begin
                            bi_next    = '0;
                            state_next = rsrf_pkg::S_BLD_LD;
                        end
                    end
                    else
                    begin
                        // emit winner, new key takes its leaf
                        out_valid_next = 1'b1;
                        key_out_next   = win_reg.key;
                        run_out_next   = rsrf_pkg::RUN_OUT_W'(win_reg.run);
                        last_out_next  = 1'b0;
                        chal_next.idx  = win_reg.idx;
                        chal_next.key  = key_in;
                        chal_next.run  = new_run;
                        chal_next.ret  = 1'b0;
                        chal_s_next    = 1'b0;
                        t_next         = tstart(win_reg.idx, size_reg);
                        mode_next      = rsrf_pkg::M_KEY;
                        state_next     = rsrf_pkg::S_RD;
                    end
                end
            end

            rsrf_pkg::S_BLD_LD:
            begin
                leaf_re    = 1'b1;
                state_next = rsrf_pkg::S_BLD_INIT;
            end

            rsrf_pkg::S_BLD_INIT:
            begin
                // leaves past the fill count stay retired
                chal_next.idx = bi_reg[IW-1:0];
                chal_next.key = leaf_q;
                chal_next.run = '0;
                chal_next.ret = (bi_reg >= fill_reg);
                chal_s_next   = 1'b0;
                t_next        = tstart(bi_reg[IW-1:0], size_reg);
                mode_next     = rsrf_pkg::M_BUILD;
                state_next    = rsrf_pkg::S_RD;
            end

            rsrf_pkg::S_RD:
            begin
                node_re    = 1'b1;
                node_ra    = t_reg;
                state_next = rsrf_pkg::S_CMP;
            end

            rsrf_pkg::S_CMP:
            begin
                if (swap)
                begin
                    node_we            = 1'b1;
                    node_wa            = t_reg;
                    node_wd            = chal_reg;
                    nset_next[t_reg]   = 1'b1;
                end
                chal_next   = c_new;
                chal_s_next = c_new_s;
                if (t_half != '0)
                begin
                    // fetch the parent while this level resolves
                    node_re = 1'b1;
                    node_ra = t_half;
                    t_next  = t_half;
                end
                else
                begin
                    win_next = c_new;
                    unique case (mode_reg)
                        rsrf_pkg::M_BUILD:
                        begin
                            bi_next = bi_reg + 1'b1;
                            if (SW'(bi_reg + 1'b1) == size_reg)
                                state_next = drain_reg ? rsrf_pkg::S_DRN_CHK
                                                       : rsrf_pkg::S_IDLE;
                            else
                                state_next = rsrf_pkg::S_BLD_LD;
                        end
                        rsrf_pkg::M_KEY:
                        begin
                            state_next = drain_reg ? rsrf_pkg::S_DRN_CHK
                                                   : rsrf_pkg::S_IDLE;
                        end
                        rsrf_pkg::M_DRAIN:
                        begin
                            state_next = rsrf_pkg::S_DRN_EMIT;
                        end
                        default:
                        begin
                            state_next = rsrf_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            rsrf_pkg::S_DRN_CHK:
            begin
                if (win_reg.ret)
                begin
                    // all leaves retired: block empty, ready for a new stream
                    fill_next  = '0;
                    nset_next  = '0;
                    drain_next = 1'b0;
                    state_next = rsrf_pkg::S_IDLE;
                end
                else
                begin
                    pend_key_next = win_reg.key;
                    pend_run_next = win_reg.run;
                    chal_next     = win_reg;
                    chal_next.ret = 1'b1;
                    chal_s_next   = 1'b0;
                    t_next        = tstart(win_reg.idx, size_reg);
                    mode_next     = rsrf_pkg::M_DRAIN;
                    state_next    = rsrf_pkg::S_RD;
                end
            end

            rsrf_pkg::S_DRN_EMIT:
            begin
                // last flag known only once the replay shows a retired winner
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    key_out_next   = pend_key_reg;
                    run_out_next   = rsrf_pkg::RUN_OUT_W'(pend_run_reg);
                    last_out_next  = win_reg.ret;
                    state_next     = rsrf_pkg::S_DRN_CHK;
                end
            end

            default:
            begin
                state_next = rsrf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsrf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            liu_reg       <= rsrf_pkg::CFG_RESET;
            mode_reg      <= rsrf_pkg::M_KEY;
            size_reg      <= SW'(LEAVES);
            fill_reg      <= '0;
            bi_reg        <= '0;
            t_reg         <= '0;
            drain_reg     <= 1'b0;
            chal_s_reg    <= 1'b0;
            nset_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                liu_reg <= cfg_wr_data;
            end
            mode_reg      <= mode_next;
            size_reg      <= size_next;
            fill_reg      <= fill_next;
            bi_reg        <= bi_next;
            t_reg         <= t_next;
            drain_reg     <= drain_next;
            chal_s_reg    <= chal_s_next;
            nset_reg      <= nset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chal_reg     <= chal_next;
        win_reg      <= win_next;
        pend_key_reg <= pend_key_next;
        pend_run_reg <= pend_run_next;
        key_out_reg  <= key_out_next;
        run_out_reg  <= run_out_next;
        last_out_reg <= last_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign key_out     = key_out_reg;
    assign run_number  = run_out_reg;
    assign output_last = last_out_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= size_reg)
        else $error("fill count above stream size");

    a_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        node_we |-> node_wa != '0)
        else $error("write to unused loser node");

    a_cmp_node: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rsrf_pkg::S_CMP |-> t_reg != '0)
        else $error("replay on node zero");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsrf_pkg::S_DRN_EMIT && out_valid_reg && out_stall)
        |=> state_reg == rsrf_pkg::S_DRN_EMIT && $stable(key_out_reg))
        else $error("drain result overwrote a held request");
`endif

endmodule

// ===== sim/tb_replacement_selection_run_former.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_replacement_selection_run_former
// Streams of signed keys drive the run former through fill, replacement and
// drain. Each accepted request is fed to a loser-tree predictor in the bench.
// Every emitted key, run and last flag is compared in order. Sizes are
// changed between streams.
// ----------------------------------------------------------------------------
module tb_replacement_selection_run_former;

    localparam int LEAVES    = 16;
    localparam int NO_LOSER  = LEAVES;     // marks an unset loser node
    localparam int SETTLE    = 400;        // covers a full tree build plus slack
    localparam int LIMIT     = 400000;
    localparam int NO_CFG    = -1;
    localparam logic signed [rsrf_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [rsrf_pkg::KEY_W-1:0] KEY_MIN = 32'sh80000000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [rsrf_pkg::CFG_W-1:0]        cfg_wr_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic signed [rsrf_pkg::KEY_W-1:0] key_in = '0;
    logic                              input_last = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [rsrf_pkg::KEY_W-1:0] key_out;
    logic [rsrf_pkg::RUN_OUT_W-1:0]    run_number;
    logic                              output_last;

    replacement_selection_run_former #(.LEAVES(LEAVES), .RUN_BITS(16)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .key_in(key_in), .input_last(input_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .key_out(key_out), .run_number(run_number), .output_last(output_last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: its own loser tree, mirrored one request at a time
    // ------------------------------------------------------------------
    typedef struct packed {
        logic signed [rsrf_pkg::KEY_W-1:0] key;
        logic [rsrf_pkg::RUN_OUT_W-1:0]    run;
        logic                              last;
    } emitted_t;

    emitted_t                           emitted_q[$];    // keys the block still owes us
    logic signed [rsrf_pkg::KEY_W-1:0]  t_key[LEAVES];
    logic [15:0]                        t_run[LEAVES];
    bit                                 t_retired[LEAVES];
    int                                 t_loser[LEAVES];
    int                                 t_fill, t_winner, t_size;
    logic [rsrf_pkg::CFG_W-1:0]         t_cfg;

    int errors = 0, n_items = 0, n_keys_out = 0, n_streams = 0, n_cfg = 0;
    bit sending = 1'b0;

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    // retired leaves lose to every live one; NO_LOSER beats everything
    function automatic bit leaf_beats(input int a, input int b);
        if (b == NO_LOSER) return 1'b0;
        if (a == NO_LOSER) return 1'b1;
        if (t_retired[a] || t_retired[b]) return !t_retired[a] && t_retired[b];
        if (t_run[a] != t_run[b]) return t_run[a] < t_run[b];
        return t_key[a] < t_key[b];
    endfunction

    function automatic void replay_path(input int leaf);
        int s;
        int node;
        int l;
        s = leaf;
        node = (leaf + t_size) >> 1;
        while (node > 0) begin
            l = t_loser[node % LEAVES];
            if (leaf_beats(l, s)) begin
                t_loser[node % LEAVES] = s;
                s = l;
            end
            node >>= 1;
        end
        t_winner = s;
    endfunction

    function automatic void clear_tree();
        for (int i = 0; i < LEAVES; i++) begin
            t_key[i] = '0;
            t_run[i] = '0;
            t_retired[i] = 1'b1;
            t_loser[i] = NO_LOSER;
        end
        t_fill = 0;
        t_winner = 0;
    endfunction

    function automatic void build_tree();
        for (int i = 0; i < LEAVES; i++) t_loser[i] = NO_LOSER;
        for (int i = 0; i < t_size; i++) replay_path(i);
    endfunction

    // returns how many keys this request adds to emitted_q
    function automatic int predict_request(input logic signed [rsrf_pkg::KEY_W-1:0] k,
                                           input bit last);
        int w;
        int n;
        emitted_t e;
        n = 0;
        if (t_fill == 0)
            t_size = (t_cfg < 2) ? 2 : (t_cfg > LEAVES) ? LEAVES : int'(t_cfg);
        if (t_fill < t_size) begin
            t_key[t_fill] = k;
            t_run[t_fill] = '0;
            t_retired[t_fill] = 1'b0;
            t_fill++;
            if (t_fill == t_size || last) build_tree();
        end else begin
            w = t_winner % LEAVES;
            e = '{key: t_key[w], run: t_run[w], last: 1'b0};
            emitted_q.push_back(e);
            n++;
            // a key below the one just emitted waits for the next run
            if (k < t_key[w] && t_run[w] != 16'hffff) t_run[w]++;
            t_key[w] = k;
            replay_path(w);
        end
        if (last) begin
            while (!t_retired[t_winner % LEAVES]) begin
                w = t_winner % LEAVES;
                e = '{key: t_key[w], run: t_run[w], last: 1'b0};
                t_retired[w] = 1'b1;
                replay_path(w);
                e.last = t_retired[t_winner % LEAVES];
                emitted_q.push_back(e);
                n++;
            end
            clear_tree();
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall pattern and checker
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 120);
        end else begin
            mode_left <= mode_left - 1;
        end
        // mode 0 never stalls, 1 stalls now and then, 2 stalls hard
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk) begin
        emitted_t e;
        if (rst_n && out_valid && !out_stall) begin
            n_keys_out++;
            if (emitted_q.size() == 0) begin
                report($sformatf("unexpected key %0d run %0d", key_out, run_number));
            end else begin
                e = emitted_q.pop_front();
                if (key_out !== e.key)
                    report($sformatf("key_out %0d, want %0d", key_out, e.key));
                if (run_number !== e.run)
                    report($sformatf("run_number %0d, want %0d", run_number, e.run));
                if (output_last !== e.last)
                    report($sformatf("output_last %0b, want %0b", output_last, e.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    int burst_left = 0;

    // first holds the first key this request adds, taken before any can drain
    task automatic send_request(input logic signed [rsrf_pkg::KEY_W-1:0] k,
                                input bit last, output int n_new,
                                output emitted_t first);
        in_valid   <= 1'b1;
        key_in     <= k;
        input_last <= last;
        sending = 1'b1;
        do @(posedge clk); while (in_stall);
        n_new = predict_request(k, last);
        first = '0;
        if (n_new != 0)
            first = emitted_q[emitted_q.size() - n_new];
        n_items++;
        // sender works in bursts; the gap after a burst is random
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                sending = 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // hold off until every owed key is out, then let a build finish
    task automatic drain_wait();
        if (sending) begin
            in_valid <= 1'b0;
            sending = 1'b0;
        end
        while (emitted_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(input logic [rsrf_pkg::CFG_W-1:0] v);
        drain_wait();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        t_cfg = v;
        n_cfg++;
    endtask

    function automatic logic signed [rsrf_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2, 3:    return $signed($urandom_range(0, 8)) - 4;   // many ties
            default: return $signed($urandom);
        endcase
    endfunction

    // directed rows; exp_* typed in where the first emitted key is obvious
    typedef struct {
        int                                cfg;
        logic signed [rsrf_pkg::KEY_W-1:0] key;
        bit                                last;
        bit                                has_exp;
        logic signed [rsrf_pkg::KEY_W-1:0] exp_key;
        logic [rsrf_pkg::RUN_OUT_W-1:0]    exp_run;
    } row_t;

    row_t rows[] = '{
        // two leaves, both extremes, then last: smallest goes out first
        '{2,      KEY_MAX, 0, 0, 0,       0},
        '{NO_CFG, KEY_MIN, 0, 0, 0,       0},
        '{NO_CFG, 0,       1, 1, KEY_MIN, 0},
        // size zero acts as two; falling keys push into the next run
        '{0,      10,      0, 0, 0,       0},
        '{NO_CFG, 20,      0, 0, 0,       0},
        '{NO_CFG, 5,       0, 1, 10,      0},
        '{NO_CFG, 15,      0, 1, 20,      0},
        '{NO_CFG, 15,      1, 1, 5,       1},
        // size 31 clamps to full tree; stream ends while still filling
        '{31,     7,       0, 0, 0,       0},
        '{NO_CFG, -3,      0, 0, 0,       0},
        '{NO_CFG, 7,       1, 0, 0,       0},
        // one-key stream
        '{3,      42,      1, 1, 42,      0},
        // full tree with equal keys then a drain
        '{16,     1,       0, 0, 0,       0},
        '{NO_CFG, 1,       0, 0, 0,       0},
        '{NO_CFG, KEY_MIN, 1, 0, 0,       0}
    };

    initial begin
        int n_new;
        int len;
        emitted_t e;
        clear_tree();
        t_cfg = rsrf_pkg::CFG_RESET;
        t_size = LEAVES;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            if (rows[i].cfg != NO_CFG) begin
                write_size(rows[i].cfg[rsrf_pkg::CFG_W-1:0]);
                n_streams++;
            end
            send_request(rows[i].key, rows[i].last, n_new, e);
            if (rows[i].has_exp) begin
                if (n_new == 0 || e.key !== rows[i].exp_key || e.run !== rows[i].exp_run)
                    report($sformatf("directed row %0d: first key not as typed", i));
            end
        end

        // random streams; small sizes are frequent, clamped values included
        while (n_items < 105) begin
            if ($urandom_range(0, 3) == 0)
                write_size(rsrf_pkg::CFG_W'($urandom_range(0, 31)));
            else if ($urandom_range(0, 1) == 0)
                write_size(rsrf_pkg::CFG_W'($urandom_range(2, 5)));
            n_streams++;
            len = $urandom_range(0, 4) == 0 ? $urandom_range(1, 6)
                                            : $urandom_range(8, 40);
            for (int j = 1; j <= len; j++)
                send_request(pick_key(), j == len, n_new, e);
        end

        drain_wait();
        foreach (emitted_q[i])
            report($sformatf("key %0d never emitted", emitted_q[i].key));
        $display("covered %0d requests in %0d streams, %0d size writes",
                 n_items, n_streams, n_cfg);
        $display("checked %0d emitted keys, %0d mismatches", n_keys_out, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== replacement_selection_run_former.f =====
rtl/rsrf_pkg.sv
rtl/replacement_selection_run_former.sv
sim/tb_replacement_selection_run_former.sv
